>>> rtl/pid_with_arrival_tracker_defines.svh
// pid_with_arrival_tracker_defines.svh
// Assertion macros shared by the PID block RTL; no dependencies.
`ifndef PID_WITH_ARRIVAL_TRACKER_DEFINES_SVH
`define PID_WITH_ARRIVAL_TRACKER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PWAT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("PID block assertion failed (same cycle)");

// next-cycle implication, disabled during reset
`define PWAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("PID block assertion failed (next cycle)");

`endif

>>> rtl/pwat_pkg.sv
// pwat_pkg.sv
// Types, codes and reset constants for the PID controller with arrival tracker.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwat_pkg;

   // operation codes of an input word; codes 6 and 7 are no-ops
   typedef enum logic [2:0] {
      OP_SAMPLE     = 3'd0,
      OP_SET_TARGET = 3'd1,
      OP_ADD_TARGET = 3'd2,
      OP_CHECK      = 3'd3,
      OP_ENABLE     = 3'd4,
      OP_FORCE      = 3'd5
   } op_type;

   // arrival tracker states
   typedef enum logic [1:0] {
      ST_FAR  = 2'd0,
      ST_NEAR = 2'd1,
      ST_DONE = 2'd2
   } arrival_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_OUT_UPPER      = 3'd3,
      CSR_OUT_LOWER      = 3'd4,
      CSR_NEAR_THRESHOLD = 3'd5,
      CSR_DONE_THRESHOLD = 3'd6,
      CSR_ANGLE_MODE     = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   // register reset values
   localparam logic signed [15:0] GAIN_P_RESET    = 16'sd883;
   localparam logic signed [15:0] GAIN_I_RESET    = 16'sd166;
   localparam logic signed [15:0] GAIN_D_RESET    = 16'sd1178;
   localparam logic signed [31:0] OUT_UPPER_RESET = 32'sd32768000;
   localparam logic signed [31:0] OUT_LOWER_RESET = -32'sd32768000;

   // settle counter saturates here
   localparam logic [3:0] SETTLE_COUNT_MAX = 4'd15;

   // 32-bit signed extremes
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // input word
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] measurement;
      logic signed [31:0] target_value;
      logic               enable;
      logic [1:0]         state_arg;
   } req_type;

   // result word
   typedef struct packed {
      logic signed [31:0] drive;
      logic [1:0]         arrival_state;
      logic               state_differs;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/pid_with_arrival_tracker.sv
// PID controller with integrator clamp and far/near/done arrival tracker.
//
// Channels: req_* carries one input word (op, measurement, target_value,
// enable, state_arg); rsp_* returns exactly one result word per input word,
// in order. Both use valid/stall: a word moves on a rising edge where valid
// is high and stall is low. csr_* is a plain write port (enable, index, data)
// for the eight configuration registers; write only while the block is idle.
//
// Throughput: one word per cycle while req_stall is low.
// The five register stages are: reciprocal multiply of the
// operand magnitude, modulo fold into one turn, setpoint / error state,
// gain multiplies, and integrator / saturation / tracker with the result
// register.
//
// Reset (synchronous, active high) empties the pipeline, loads the register
// defaults, clears setpoint, integrator and last error, enables the loop and
// puts the tracker in far. When rsp_stall holds a result, the stages behind
// it keep filling, and req_stall rises only once every stage holds a word.
//
// Depends on pwat_pkg and pid_with_arrival_tracker_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "pid_with_arrival_tracker_defines.svh"

module pid_with_arrival_tracker #(
   parameter int HALF_TURN    = 11796480,
   parameter int SETTLE_LIMIT = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire pwat_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output pwat_pkg::rsp_type                           rsp_data,
   input  wire logic                                   csr_write_en,
   input  wire logic [pwat_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [pwat_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   import pwat_pkg::*;

   // ---------------------------------------------------------------
   // Turn constants, worked out at elaboration
   // ---------------------------------------------------------------
   localparam longint HalfL      = longint'(HALF_TURN);
   localparam longint FullL      = 2 * HalfL;
   localparam longint RecipL     = (longint'(1) << 32) / FullL;
   localparam longint S32MaxL    = (longint'(1) << 31) - 1;
   localparam longint S32MinL    = -(longint'(1) << 31);
   localparam longint ResMaxRawL = S32MaxL % FullL;
   localparam longint ResMinRawL = S32MinL % FullL;
   localparam longint ResMaxL    = (ResMaxRawL > HalfL) ? ResMaxRawL - FullL : ResMaxRawL;
   localparam longint ResMinL    = (ResMinRawL <= -HalfL) ? ResMinRawL + FullL : ResMinRawL;

   localparam logic [31:0]        HalfU  = 32'(HalfL);
   localparam logic [31:0]        FullU  = 32'(FullL);
   localparam logic [31:0]        RecipU = 32'(RecipL);
   localparam logic signed [31:0] HalfS  = 32'(HalfL);
   localparam logic signed [32:0] HalfS33 = 33'(HalfL);
   localparam logic signed [32:0] FullS33 = 33'(FullL);
   localparam logic signed [31:0] ResMax = 32'(ResMaxL);
   localparam logic signed [31:0] ResMin = 32'(ResMinL);
   localparam logic [3:0]         SettleLimit = 4'(SETTLE_LIMIT);

   // ---------------------------------------------------------------
   // Stage payload types
   // ---------------------------------------------------------------
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] measurement;
      logic signed [31:0] target_value;
      logic               enable;
      logic [1:0]         state_arg;
      logic               neg;
      logic [31:0]        mag;
      logic [31:0]        quot;
   } s1_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] measurement;
      logic signed [31:0] target_value;
      logic               enable;
      logic [1:0]         state_arg;
      logic signed [31:0] resid;
   } s2_type;

   typedef struct packed {
      logic [2:0]         op;
      logic               go;
      logic signed [31:0] err;
      logic signed [32:0] err_delta;
      logic signed [31:0] prev;
      logic [1:0]         state_arg;
   } s3_type;

   typedef struct packed {
      logic [2:0]         op;
      logic               go;
      logic signed [39:0] i_term;
      logic signed [41:0] pd_term;
      logic signed [31:0] prev;
      logic [1:0]         state_arg;
   } s4_type;

   // fold a sum of two residues back into (-HALF_TURN, HALF_TURN]
   function automatic logic signed [31:0] wrap_fold(input logic signed [32:0] v);
      logic signed [32:0] t;
      t = v;
      if (t > HalfS33) begin
         t = t - FullS33;
      end else if (t <= -HalfS33) begin
         t = t + FullS33;
      end
      return 32'(t);
   endfunction

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic signed [15:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [31:0] out_upper_ff, out_lower_ff;
   logic [30:0]        near_thr_ff, done_thr_ff;
   logic               angle_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff     <= GAIN_P_RESET;
         gain_i_ff     <= GAIN_I_RESET;
         gain_d_ff     <= GAIN_D_RESET;
         out_upper_ff  <= OUT_UPPER_RESET;
         out_lower_ff  <= OUT_LOWER_RESET;
         near_thr_ff   <= '0;
         done_thr_ff   <= '0;
         angle_mode_ff <= 1'b0;
      end else if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:         gain_p_ff     <= csr_wdata[15:0];
            CSR_GAIN_I:         gain_i_ff     <= csr_wdata[15:0];
            CSR_GAIN_D:         gain_d_ff     <= csr_wdata[15:0];
            CSR_OUT_UPPER:      out_upper_ff  <= csr_wdata;
            CSR_OUT_LOWER:      out_lower_ff  <= csr_wdata;
            CSR_NEAR_THRESHOLD: near_thr_ff   <= csr_wdata[30:0];
            CSR_DONE_THRESHOLD: done_thr_ff   <= csr_wdata[30:0];
            CSR_ANGLE_MODE:     angle_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Pipeline flow control
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic v1_in, v2_in, v3_in, v4_in, rsp_valid_in;
   logic adv1, adv2, adv3, adv4, adv5;
   logic ld3, ld5;

   assign adv5 = !rsp_valid_ff || !rsp_stall;
   assign adv4 = !v4_ff || adv5;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;
   assign ld3  = v2_ff && adv3;
   assign ld5  = v4_ff && adv5;

   assign v1_in        = adv1 ? req_valid : v1_ff;
   assign v2_in        = adv2 ? v1_ff : v2_ff;
   assign v3_in        = adv3 ? v2_ff : v3_ff;
   assign v4_in        = adv4 ? v3_ff : v4_ff;
   assign rsp_valid_in = adv5 ? v4_ff : rsp_valid_ff;

   assign req_stall = !adv1;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         v3_ff        <= v3_in;
         v4_ff        <= v4_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: operand magnitude times reciprocal of one turn
   // ---------------------------------------------------------------
   s1_type             s1_ff, s1_in;
   logic signed [31:0] sel_w;
   logic [63:0]        recip_prod_w;

   always_comb begin
      sel_w              = (req_data.op == OP_SAMPLE) ? req_data.measurement
                                                      : req_data.target_value;
      s1_in.op           = req_data.op;
      s1_in.measurement  = req_data.measurement;
      s1_in.target_value = req_data.target_value;
      s1_in.enable       = req_data.enable;
      s1_in.state_arg    = req_data.state_arg;
      s1_in.neg          = sel_w[31];
      s1_in.mag          = sel_w[31] ? (~sel_w + 32'd1) : sel_w;
      recip_prod_w       = 64'(s1_in.mag) * 64'(RecipU);
      s1_in.quot         = recip_prod_w[63:32];
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: remainder, one correction, fold into (-half, half]
   // ---------------------------------------------------------------
   s2_type      s2_ff, s2_in;
   logic [63:0] qf_w;
   logic [32:0] rem0_w, rem0_sub_w;
   logic [31:0] rem1_w, pos_w;

   always_comb begin
      qf_w       = 64'(s1_ff.quot) * 64'(FullU);
      rem0_w     = {1'b0, s1_ff.mag} - qf_w[32:0];
      rem0_sub_w = rem0_w - {1'b0, FullU};
      rem1_w     = (rem0_w >= {1'b0, FullU}) ? rem0_sub_w[31:0] : rem0_w[31:0];
      pos_w      = (s1_ff.neg && (rem1_w != 32'd0)) ? (FullU - rem1_w) : rem1_w;

      s2_in.op           = s1_ff.op;
      s2_in.measurement  = s1_ff.measurement;
      s2_in.target_value = s1_ff.target_value;
      s2_in.enable       = s1_ff.enable;
      s2_in.state_arg    = s1_ff.state_arg;
      s2_in.resid        = (pos_w > HalfU) ? $signed(pos_w - FullU) : $signed(pos_w);
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: setpoint, last error, loop enable; forms the error
   // ---------------------------------------------------------------
   s3_type             s3_ff, s3_in;
   logic signed [31:0] setpoint_ff, setpoint_in;
   logic signed [31:0] sp_resid_ff, sp_resid_in;
   logic signed [31:0] prev_err_ff, prev_err_in;
   logic               running_ff, running_in;
   logic signed [32:0] diff_w, sum_w;
   logic signed [31:0] err_plain_w, err_angle_w;

   always_comb begin
      // plain error saturates, angle error comes from the two residues
      diff_w      = 33'(setpoint_ff) - 33'(s2_ff.measurement);
      err_plain_w = (diff_w[32] != diff_w[31]) ? (diff_w[32] ? S32_MIN : S32_MAX)
                                               : diff_w[31:0];
      err_angle_w = wrap_fold(33'(sp_resid_ff) - 33'(s2_ff.resid));
      sum_w       = 33'(setpoint_ff) + 33'(s2_ff.target_value);

      setpoint_in = setpoint_ff;
      sp_resid_in = sp_resid_ff;
      prev_err_in = prev_err_ff;
      running_in  = running_ff;

      s3_in.op        = s2_ff.op;
      s3_in.go        = 1'b0;
      s3_in.err       = angle_mode_ff ? err_angle_w : err_plain_w;
      s3_in.err_delta = 33'(s3_in.err) - 33'(prev_err_ff);
      s3_in.prev      = prev_err_ff;
      s3_in.state_arg = s2_ff.state_arg;

      case (s2_ff.op)
         OP_SAMPLE: begin
            if (running_ff) begin
               s3_in.go    = 1'b1;
               prev_err_in = s3_in.err;
            end
         end
         OP_SET_TARGET: begin
            setpoint_in = s2_ff.target_value;
            sp_resid_in = s2_ff.resid;
         end
         OP_ADD_TARGET: begin
            if (sum_w[32] != sum_w[31]) begin
               setpoint_in = sum_w[32] ? S32_MIN : S32_MAX;
               sp_resid_in = sum_w[32] ? ResMin : ResMax;
            end else begin
               setpoint_in = sum_w[31:0];
               sp_resid_in = wrap_fold(33'(sp_resid_ff) + 33'(s2_ff.resid));
            end
         end
         OP_ENABLE: begin
            running_in  = s2_ff.enable;
            prev_err_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         sp_resid_ff <= '0;
         prev_err_ff <= '0;
         running_ff  <= 1'b1;
      end else if (ld3) begin
         setpoint_ff <= setpoint_in;
         sp_resid_ff <= sp_resid_in;
         prev_err_ff <= prev_err_in;
         running_ff  <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: gain products, floor-shifted to Q15.16
   // ---------------------------------------------------------------
   s4_type             s4_ff, s4_in;
   logic signed [47:0] p_prod_w, i_prod_w;
   logic signed [48:0] d_prod_w;

   always_comb begin
      p_prod_w = 48'(gain_p_ff) * 48'($signed(s3_ff.err));
      i_prod_w = 48'(gain_i_ff) * 48'($signed(s3_ff.err));
      d_prod_w = 49'(gain_d_ff) * 49'($signed(s3_ff.err_delta));

      s4_in.op        = s3_ff.op;
      s4_in.go        = s3_ff.go;
      s4_in.i_term    = 40'(i_prod_w >>> 8);
      s4_in.pd_term   = 42'(p_prod_w >>> 8) + 42'(d_prod_w >>> 8);
      s4_in.prev      = s3_ff.prev;
      s4_in.state_arg = s3_ff.state_arg;
   end

   always_ff @(posedge clock) begin
      if (adv4) begin
         s4_ff <= s4_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 5: integrator clamp, drive saturation, arrival tracker
   // ---------------------------------------------------------------
   rsp_type            rsp_ff, rsp_in;
   logic signed [31:0] integ_ff, integ_in;
   arrival_type        arrival_ff, arrival_in;
   logic [3:0]         settle_ff, settle_in;
   logic signed [41:0] ival_w, iclamp_w;
   logic signed [42:0] osum_w;
   logic [31:0]        err_mag_w;
   logic [3:0]         settle_step_w;
   arrival_type        arrival_step_w;

   // tracker step on the magnitude of the last error
   always_comb begin
      err_mag_w      = s4_ff.prev[31] ? (~s4_ff.prev + 32'd1) : s4_ff.prev;
      arrival_step_w = arrival_ff;
      settle_step_w  = settle_ff;
      unique case (arrival_ff)
         ST_FAR: begin
            if (err_mag_w < {1'b0, near_thr_ff}) begin
               arrival_step_w = ST_NEAR;
            end
         end
         ST_NEAR: begin
            if (err_mag_w < {1'b0, done_thr_ff}) begin
               if (settle_ff != SETTLE_COUNT_MAX) begin
                  settle_step_w = settle_ff + 4'd1;
               end
            end else if (err_mag_w > {1'b0, near_thr_ff}) begin
               settle_step_w = '0;
            end
            if (settle_step_w > SettleLimit) begin
               arrival_step_w = ST_DONE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      // integrator: clamp to upper, then to lower
      ival_w   = 42'(integ_ff) + 42'(s4_ff.i_term);
      iclamp_w = ival_w;
      if (iclamp_w > 42'(out_upper_ff)) begin
         iclamp_w = 42'(out_upper_ff);
      end
      if (iclamp_w < 42'(out_lower_ff)) begin
         iclamp_w = 42'(out_lower_ff);
      end
      osum_w = 43'(s4_ff.pd_term) + 43'(iclamp_w);

      integ_in   = integ_ff;
      arrival_in = arrival_ff;
      settle_in  = settle_ff;

      rsp_in.drive         = '0;
      rsp_in.state_differs = 1'b0;

      case (s4_ff.op)
         OP_SAMPLE: begin
            if (s4_ff.go) begin
               integ_in = 32'(iclamp_w);
               if (osum_w > 43'(out_upper_ff)) begin
                  rsp_in.drive = out_upper_ff;
               end else if (osum_w < 43'(out_lower_ff)) begin
                  rsp_in.drive = out_lower_ff;
               end else begin
                  rsp_in.drive = 32'(osum_w);
               end
            end
         end
         OP_CHECK: begin
            arrival_in           = arrival_step_w;
            settle_in            = settle_step_w;
            rsp_in.state_differs = (arrival_step_w != s4_ff.state_arg);
         end
         OP_ENABLE: begin
            integ_in   = '0;
            arrival_in = ST_FAR;
            settle_in  = '0;
         end
         OP_FORCE: begin
            // the unused state code is ignored
            if (s4_ff.state_arg <= ST_DONE) begin
               arrival_in = arrival_type'(s4_ff.state_arg);
            end
         end
         default: ;
      endcase

      rsp_in.arrival_state = arrival_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff   <= '0;
         arrival_ff <= ST_FAR;
         settle_ff  <= '0;
      end else if (ld5) begin
         integ_ff   <= integ_in;
         arrival_ff <= arrival_in;
         settle_ff  <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv5) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   `PWAT_ASSERT_IMPL(a_resid_range, clock, reset, v2_ff,
      (s2_ff.resid > -HalfS) && (s2_ff.resid <= HalfS))
   `PWAT_ASSERT_NEXT(a_idle_drive_zero, clock, reset, ld5 && (s4_ff.op != OP_SAMPLE),
      rsp_data.drive == 32'sd0)
   `PWAT_ASSERT_NEXT(a_far_not_done, clock, reset,
      ld5 && (s4_ff.op == OP_CHECK) && (arrival_ff == ST_FAR), arrival_ff != ST_DONE)
   `PWAT_ASSERT_NEXT(a_stage4_hold, clock, reset, v4_ff && !adv5,
      v4_ff && $stable(s4_ff))

endmodule

`default_nettype wire

>>> dv/pid_with_arrival_tracker_checker.sv
`timescale 1ns / 1ps
// Checker for the PID block: tracks config writes, predicts each result word and compares.
// Depends on pwat_pkg for word types, codes and reset values.

module pid_with_arrival_tracker_checker #(
   parameter int HALF_TURN    = 11796480,
   parameter int SETTLE_LIMIT = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  pwat_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  pwat_pkg::rsp_type rsp_data,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                error_count,
   output int                outstanding
);

   import pwat_pkg::*;

   // shadow configuration
   logic signed [15:0] kp, ki, kd;
   logic signed [31:0] lim_hi, lim_lo;
   logic [30:0]        near_thr, done_thr;
   logic               angle_on;

   // shadow controller and tracker state
   logic signed [31:0] setpoint, integ, last_err;
   logic               loop_on;
   arrival_type        trk_state;
   logic [3:0]         settle_cnt;

   rsp_type expected_words[$];
   rsp_type exp_w;
   int      errors = 0;

   function automatic logic signed [31:0] clip32(input longint v);
      if (v > longint'(S32_MAX)) return S32_MAX;
      if (v < longint'(S32_MIN)) return S32_MIN;
      return v[31:0];
   endfunction

   // Q7.8 gain times Q15.16 value; arithmetic shift floors the result
   function automatic longint scale_gain(input logic signed [15:0] g, input longint x);
      return (longint'(g) * x) >>> 8;
   endfunction

   // one PID update; returns the saturated drive
   function automatic logic signed [31:0] pid_update(input logic signed [31:0] meas);
      longint diff, rem, acc, out, full;
      logic signed [31:0] e;
      full = 2 * longint'(HALF_TURN);
      diff = longint'(setpoint) - longint'(meas);
      if (angle_on) begin
         // heading difference folded into (-half turn, half turn]
         rem = diff % full;
         if (rem > longint'(HALF_TURN)) rem -= full;
         if (rem <= -longint'(HALF_TURN)) rem += full;
         e = clip32(rem);
      end else begin
         e = clip32(diff);
      end
      // integrator clamp: upper first, so crossed limits end at the lower one
      acc = longint'(integ) + scale_gain(ki, longint'(e));
      if (acc > longint'(lim_hi)) acc = longint'(lim_hi);
      if (acc < longint'(lim_lo)) acc = longint'(lim_lo);
      integ = acc[31:0];
      out = scale_gain(kp, longint'(e)) + acc
          + scale_gain(kd, longint'(e) - longint'(last_err));
      if (out > longint'(lim_hi)) out = longint'(lim_hi);
      else if (out < longint'(lim_lo)) out = longint'(lim_lo);
      last_err = e;
      return out[31:0];
   endfunction

   // far -> near -> done stepping on the last error magnitude
   function automatic void arrival_step();
      longint mag;
      mag = (last_err < 0) ? -longint'(last_err) : longint'(last_err);
      case (trk_state)
         ST_FAR: begin
            if (mag < longint'({1'b0, near_thr})) trk_state = ST_NEAR;
         end
         ST_NEAR: begin
            if (mag < longint'({1'b0, done_thr})) begin
               if (settle_cnt != SETTLE_COUNT_MAX) settle_cnt = settle_cnt + 4'd1;
            end else if (mag > longint'({1'b0, near_thr})) begin
               settle_cnt = '0;
            end
            if (int'(settle_cnt) > SETTLE_LIMIT) trk_state = ST_DONE;
         end
         default: ;
      endcase
   endfunction

   function automatic rsp_type compute_response(input req_type w);
      rsp_type r;
      r = '0;
      case (w.op)
         OP_SAMPLE: begin
            if (loop_on) r.drive = pid_update($signed(w.measurement));
         end
         OP_SET_TARGET: setpoint = w.target_value;
         OP_ADD_TARGET: setpoint = clip32(longint'(setpoint) + longint'($signed(w.target_value)));
         OP_CHECK: begin
            arrival_step();
            r.state_differs = (trk_state != w.state_arg);
         end
         OP_ENABLE: begin
            loop_on    = w.enable;
            integ      = '0;
            last_err   = '0;
            trk_state  = ST_FAR;
            settle_cnt = '0;
         end
         OP_FORCE: begin
            // the spare state code is ignored
            if (w.state_arg <= ST_DONE) trk_state = arrival_type'(w.state_arg);
         end
         default: ;
      endcase
      r.arrival_state = trk_state;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         kp         = GAIN_P_RESET;
         ki         = GAIN_I_RESET;
         kd         = GAIN_D_RESET;
         lim_hi     = OUT_UPPER_RESET;
         lim_lo     = OUT_LOWER_RESET;
         near_thr   = '0;
         done_thr   = '0;
         angle_on   = 1'b0;
         setpoint   = '0;
         integ      = '0;
         last_err   = '0;
         loop_on    = 1'b1;
         trk_state  = ST_FAR;
         settle_cnt = '0;
         expected_words.delete();
      end else begin
         // result side: compare against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected result word: drive %0d state %0d differs %0d",
                        $time, rsp_data.drive, rsp_data.arrival_state,
                        rsp_data.state_differs);
            end else begin
               exp_w = expected_words.pop_front();
               if (rsp_data.drive !== exp_w.drive) begin
                  errors++;
                  $display("%0t: drive mismatch: expected %0d actual %0d",
                           $time, exp_w.drive, rsp_data.drive);
               end
               if (rsp_data.arrival_state !== exp_w.arrival_state) begin
                  errors++;
                  $display("%0t: arrival_state mismatch: expected %0d actual %0d",
                           $time, exp_w.arrival_state, rsp_data.arrival_state);
               end
               if (rsp_data.state_differs !== exp_w.state_differs) begin
                  errors++;
                  $display("%0t: state_differs mismatch: expected %0d actual %0d",
                           $time, exp_w.state_differs, rsp_data.state_differs);
               end
            end
         end
         // config writes
         if (csr_write_en) begin
            case (csr_index)
               CSR_GAIN_P:         kp       = csr_wdata[15:0];
               CSR_GAIN_I:         ki       = csr_wdata[15:0];
               CSR_GAIN_D:         kd       = csr_wdata[15:0];
               CSR_OUT_UPPER:      lim_hi   = csr_wdata;
               CSR_OUT_LOWER:      lim_lo   = csr_wdata;
               CSR_NEAR_THRESHOLD: near_thr = csr_wdata[30:0];
               CSR_DONE_THRESHOLD: done_thr = csr_wdata[30:0];
               CSR_ANGLE_MODE:     angle_on = csr_wdata[0];
               default: ;
            endcase
         end
         // request side: predict the result word
         if (req_valid && !req_stall) expected_words.push_back(compute_response(req_data));
      end
      error_count <= errors;
      outstanding <= expected_words.size();
   end

endmodule

>>> dv/pid_with_arrival_tracker_tb.sv
`timescale 1ns / 1ps
// Top of the PID block bench: clock, reset, stimulus, stall patterns and verdict.
// Depends on pwat_pkg, pid_with_arrival_tracker and pid_with_arrival_tracker_checker.

module pid_with_arrival_tracker_tb;
   import pwat_pkg::*;

   localparam int HALF_TURN       = 11796480;
   localparam int SETTLE_LIMIT    = 8;
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 135;
   localparam int HOLD_CYCLES     = 100;
   localparam int DRAIN_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT  = 2000;

   // op codes with no function, and the spare tracker state code
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;
   localparam logic [1:0] ST_SPARE   = 2'd3;
   localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

   typedef struct {
      logic signed [15:0] kp, ki, kd;
      logic signed [31:0] hi, lo;
      logic [30:0]        near_thr, done_thr;
      logic               angle;
   } tuning_type;

   logic        clock        = 1'b0;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   req_type     req_data     = '0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index    = '0;
   logic [31:0] csr_wdata    = '0;

   int error_count;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;
   int words_sent    = 0;

   pid_with_arrival_tracker #(
      .HALF_TURN    (HALF_TURN),
      .SETTLE_LIMIT (SETTLE_LIMIT)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   pid_with_arrival_tracker_checker #(
      .HALF_TURN    (HALF_TURN),
      .SETTLE_LIMIT (SETTLE_LIMIT)
   ) checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .outstanding  (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stall, or a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_requests != holds_served) begin
         rsp_stall    <= 1'b1;
         hold_left    <= HOLD_CYCLES - 1;
         holds_served <= holds_served + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // watchdog: cycles in which no word moves on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic req_type make_word(input logic [2:0] op,
                                         input logic signed [31:0] meas,
                                         input logic signed [31:0] aim,
                                         input logic on, input logic [1:0] sarg);
      req_type w;
      w.op           = op;
      w.measurement  = meas;
      w.target_value = aim;
      w.enable       = on;
      w.state_arg    = sarg;
      return w;
   endfunction

   // extremes, full-range and near-zero values
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(19);
      if (r == 0) return S32_MAX;
      if (r == 1) return S32_MIN;
      if (r == 2) return 32'sd0;
      if (r == 3) return -32'sd1;
      if (r < 12) return $urandom;
      return 32'($urandom_range(0, 1 << 25)) - 32'sd16777216;
   endfunction

   function automatic req_type random_word();
      req_type w;
      int r;
      r = $urandom_range(99);
      w.measurement  = pick_value();
      w.target_value = pick_value();
      w.enable       = ($urandom_range(99) < 85);
      w.state_arg    = 2'($urandom_range(3));
      if (r < 40) w.op = OP_SAMPLE;
      else if (r < 50) w.op = OP_SET_TARGET;
      else if (r < 60) w.op = OP_ADD_TARGET;
      else if (r < 80) w.op = OP_CHECK;
      else if (r < 87) w.op = OP_ENABLE;
      else if (r < 95) w.op = OP_FORCE;
      else if (r < 98) w.op = OP_SPARE_A;
      else w.op = OP_SPARE_B;
      return w;
   endfunction

   // offer one word; called at a clock edge, returns at the edge that accepts it
   task automatic put_word(input req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // drop valid and wait for every predicted word to come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
   endtask

   task automatic apply_config(input tuning_type t);
      write_reg(CSR_GAIN_P, 32'(t.kp));
      write_reg(CSR_GAIN_I, 32'(t.ki));
      write_reg(CSR_GAIN_D, 32'(t.kd));
      write_reg(CSR_OUT_UPPER, t.hi);
      write_reg(CSR_OUT_LOWER, t.lo);
      write_reg(CSR_NEAR_THRESHOLD, {1'b0, t.near_thr});
      write_reg(CSR_DONE_THRESHOLD, {1'b0, t.done_thr});
      write_reg(CSR_ANGLE_MODE, {31'd0, t.angle});
      csr_write_en <= 1'b0;
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct <= 0;  end
         1: begin send_idle_pct = 45; stall_pct <= 0;  end
         2: begin send_idle_pct = 0;  stall_pct <= 45; end
         default: begin send_idle_pct = 36; stall_pct <= 36; end
      endcase
   endtask

   initial begin
      tuning_type         t;
      req_type            w;
      logic signed [31:0] aim, lim_a, lim_b;
      longint             miss, meas_l;
      int                 phase, phase_end, steps, jitter;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_idle(0);

      // directed words at the reset configuration
      put_word(make_word(OP_SAMPLE, 32'sd0, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, S32_MAX, 32'sd0, 1'b0, ST_DONE));
      put_word(make_word(OP_SAMPLE, S32_MIN, S32_MAX, 1'b1, ST_SPARE));
      // setpoint overflow each way, each followed by error overflow
      put_word(make_word(OP_SET_TARGET, 32'sd0, S32_MAX, 1'b0, ST_FAR));
      put_word(make_word(OP_ADD_TARGET, 32'sd0, S32_MAX, 1'b0, ST_FAR));
      put_word(make_word(OP_SAMPLE, S32_MIN, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SET_TARGET, 32'sd0, S32_MIN, 1'b1, ST_FAR));
      put_word(make_word(OP_ADD_TARGET, 32'sd0, S32_MIN, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, S32_MAX, 32'sd0, 1'b1, ST_FAR));
      // tracker compare, spare codes, forced states
      put_word(make_word(OP_CHECK, 32'sd0, 32'sd0, 1'b1, ST_SPARE));
      put_word(make_word(OP_CHECK, 32'sd0, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_FORCE, 32'sd0, 32'sd0, 1'b1, ST_SPARE));
      put_word(make_word(OP_FORCE, 32'sd0, 32'sd0, 1'b1, ST_NEAR));
      put_word(make_word(OP_CHECK, 32'sd0, 32'sd0, 1'b1, ST_NEAR));
      put_word(make_word(OP_FORCE, 32'sd0, 32'sd0, 1'b1, ST_DONE));
      put_word(make_word(OP_CHECK, 32'sd0, 32'sd0, 1'b1, ST_DONE));
      // loop off, then back on
      put_word(make_word(OP_ENABLE, 32'sd0, 32'sd0, 1'b0, ST_FAR));
      put_word(make_word(OP_SAMPLE, 32'sd12345, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_ENABLE, 32'sd0, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SPARE_A, -32'sd1, -32'sd1, 1'b1, ST_SPARE));
      put_word(make_word(OP_SPARE_B, -32'sd1, -32'sd1, 1'b1, ST_SPARE));
      put_word(make_word(OP_SET_TARGET, 32'sd0, 100 * ONE_Q16, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, 99 * ONE_Q16, 32'sd0, 1'b1, ST_FAR));

      // angle wrap with crossed limits
      settle();
      t.kp       = GAIN_P_RESET;
      t.ki       = GAIN_I_RESET;
      t.kd       = GAIN_D_RESET;
      t.hi       = 10 * ONE_Q16;
      t.lo       = 20 * ONE_Q16;
      t.near_thr = 31'(10 * ONE_Q16);
      t.done_thr = 31'(ONE_Q16);
      t.angle    = 1'b1;
      apply_config(t);
      set_idle(3);
      put_word(make_word(OP_SET_TARGET, 32'sd0, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, HALF_TURN, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, -HALF_TURN, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, 3 * HALF_TURN + 5, 32'sd0, 1'b1, ST_FAR));
      put_word(make_word(OP_SAMPLE, S32_MIN, 32'sd0, 1'b1, ST_FAR));

      // random phases, each with its own tuning and idle pattern
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         lim_a      = $urandom;
         lim_b      = $urandom;
         t.kp       = 16'($urandom);
         t.ki       = 16'($urandom);
         t.kd       = 16'($urandom);
         t.hi       = 32'($urandom_range(0, 1 << 28));
         t.lo       = -32'($urandom_range(0, 1 << 28));
         t.near_thr = 31'($urandom_range(0, 1 << 22));
         t.done_thr = 31'($urandom_range(0, 1 << 20));
         t.angle    = 1'($urandom_range(1));
         case (phase)
            0: begin
               t.kp = GAIN_P_RESET; t.ki = GAIN_I_RESET; t.kd = GAIN_D_RESET;
               t.hi = OUT_UPPER_RESET; t.lo = OUT_LOWER_RESET;
               t.near_thr = 31'(10 * ONE_Q16); t.done_thr = 31'(ONE_Q16);
               t.angle = 1'b0;
            end
            1: begin
               t.kp = 16'sh7FFF; t.ki = 16'sh7FFF; t.kd = 16'sh7FFF;
               t.hi = S32_MAX; t.lo = S32_MIN;
               t.near_thr = 31'h7FFF_FFFF; t.done_thr = 31'h7FFF_FFFF;
            end
            2: begin
               // crossed limits
               t.lo    = t.hi + 32'($urandom_range(1, 1 << 24));
               t.angle = 1'b0;
            end
            3: begin
               t.kp = 16'sh8000; t.ki = 16'sh8000; t.kd = 16'sh8000;
               t.near_thr = '0; t.done_thr = '0;
               t.angle = 1'b1;
            end
            7: begin
               t.hi = (lim_a > lim_b) ? lim_a : lim_b;
               t.lo = (lim_a > lim_b) ? lim_b : lim_a;
               t.near_thr = 31'($urandom); t.done_thr = 31'($urandom);
            end
            default: ;
         endcase
         apply_config(t);
         set_idle(phase % 4);
         phase_end = words_sent + WORDS_PER_PHASE;
         while (words_sent < phase_end) begin
            // one long receiver hold-off while words keep coming
            if (phase == 2 && hold_requests == 0 && words_sent > phase_end - 100)
               hold_requests <= 1;
            if ($urandom_range(99) < 60) begin
               // approach: new target, samples closing in, each followed by a check
               aim = ($urandom_range(3) == 0) ? pick_value()
                     : 32'($urandom_range(0, 1 << 25)) - 32'sd16777216;
               w = random_word();
               w.op = OP_SET_TARGET;
               w.target_value = aim;
               put_word(w);
               if ($urandom_range(2) == 0) begin
                  w = random_word();
                  w.op = OP_ENABLE;
                  w.enable = 1'b1;
                  put_word(w);
               end
               miss  = longint'($urandom_range(0, 1 << 22)) - (longint'(1) << 21);
               steps = $urandom_range(6, 20);
               repeat (steps) begin
                  meas_l = longint'(aim) - miss;
                  if (meas_l > longint'(S32_MAX)) meas_l = longint'(S32_MAX);
                  else if (meas_l < longint'(S32_MIN)) meas_l = longint'(S32_MIN);
                  w = random_word();
                  w.op = OP_SAMPLE;
                  w.measurement = meas_l[31:0];
                  put_word(w);
                  w = random_word();
                  w.op = OP_CHECK;
                  put_word(w);
                  jitter = $urandom_range(0, 2);
                  if ($urandom_range(7) == 0)
                     miss = longint'($urandom_range(0, 1 << 22)) - (longint'(1) << 21);
                  else
                     miss = miss / 2 + jitter - 1;
               end
            end else begin
               put_word(random_word());
            end
         end
      end

      settle();
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
